// ===== sv/lhm_pkg.sv =====
// ----------------------------------------------------------------------------
// lhm_pkg
// shared types and constants of the link health hysteresis monitor
// ----------------------------------------------------------------------------
`default_nettype none

package lhm_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned LimitWidth = 8;
  localparam int unsigned RttWidth   = 15;
  localparam int unsigned HoldWidth  = 16;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned TotalWidth = 32;

  localparam logic [LimitWidth-1:0] DefFailLimit = 8'd3;
  localparam logic [LimitWidth-1:0] RunMax       = 8'd255;
  localparam logic [HoldWidth-1:0]  RttNone      = 16'hFFFF;

  localparam logic OpProbe        = 1'b0;
  localparam logic OpForceUnknown = 1'b1;

  localparam logic [1:0] LinkUnknown  = 2'd0;
  localparam logic [1:0] LinkUp       = 2'd1;
  localparam logic [1:0] LinkDegraded = 2'd2;
  localparam logic [1:0] LinkDown     = 2'd3;

  typedef enum logic [3:0] {
    ST_UNKNOWN  = 4'b0001,
    ST_UP       = 4'b0010,
    ST_DEGRADED = 4'b0100,
    ST_DOWN     = 4'b1000
  } link_state_e;

  typedef enum logic [2:0] {
    NOTICE_NONE       = 3'd0,
    NOTICE_BACK_UP    = 3'd1,
    NOTICE_DOWN       = 3'd2,
    NOTICE_LOOKUP_BAD = 3'd3,
    NOTICE_ECHO_BAD   = 3'd4
  } notice_e;

  typedef struct packed {
    logic                 op;
    logic                 echo_ok;
    logic                 lookup_ok;
    logic [RttWidth-1:0]  round_trip_ms;
    logic [TimeWidth-1:0] now_seconds;
  } item_t;

  typedef struct packed {
    logic [1:0]                  link_state;
    logic [1:0]                  prior_state;
    logic                        state_changed;
    logic [2:0]                  notice;
    logic [TotalWidth-1:0]       check_total;
    logic [TotalWidth-1:0]       failure_total;
    logic signed [HoldWidth-1:0] last_round_trip;
    logic                        last_echo_ok;
    logic                        last_lookup_ok;
    logic [TimeWidth-1:0]        last_check_time;
    logic [TimeWidth-1:0]        changed_time;
  } result_t;

  function automatic logic [1:0] state_code(link_state_e st);
    logic [1:0] code;
    unique case (st)
      ST_UNKNOWN:  code = LinkUnknown;
      ST_UP:       code = LinkUp;
      ST_DEGRADED: code = LinkDegraded;
      ST_DOWN:     code = LinkDown;
      default:     code = LinkUnknown;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== sv/lhm_in_if.sv =====
// ----------------------------------------------------------------------------
// lhm_in_if
// probe request channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface lhm_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic        echo_ok;
  logic        lookup_ok;
  logic [14:0] round_trip_ms;
  logic [31:0] now_seconds;

  modport source (
    output valid, op, echo_ok, lookup_ok, round_trip_ms, now_seconds,
    input  ready
  );
  modport sink (
    input  valid, op, echo_ok, lookup_ok, round_trip_ms, now_seconds,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/lhm_out_if.sv =====
// ----------------------------------------------------------------------------
// lhm_out_if
// link status result channel with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface lhm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         link_state;
  logic [1:0]         prior_state;
  logic               state_changed;
  logic [2:0]         notice;
  logic [31:0]        check_total;
  logic [31:0]        failure_total;
  logic signed [15:0] last_round_trip;
  logic               last_echo_ok;
  logic               last_lookup_ok;
  logic [31:0]        last_check_time;
  logic [31:0]        changed_time;

  modport source (
    output valid, link_state, prior_state, state_changed, notice, check_total,
           failure_total, last_round_trip, last_echo_ok, last_lookup_ok,
           last_check_time, changed_time,
    input  ready
  );
  modport sink (
    input  valid, link_state, prior_state, state_changed, notice, check_total,
           failure_total, last_round_trip, last_echo_ok, last_lookup_ok,
           last_check_time, changed_time,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/lhm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lhm_cfg_if
// configuration write channel for the failure streak limit
// ----------------------------------------------------------------------------
`default_nettype none

interface lhm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] fail_streak_limit;

  modport source (output valid, fail_streak_limit, input ready);
  modport sink (input valid, fail_streak_limit, output ready);
endinterface

`default_nettype wire

// ===== sv/lhm_core.sv =====
// ----------------------------------------------------------------------------
// lhm_core
// verdict, hysteresis state machine, counters and probe history
// ----------------------------------------------------------------------------
`default_nettype none

module lhm_core #(
  parameter int unsigned COUNT_WIDTH = lhm_pkg::CountWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                fire_i,
  input  logic [lhm_pkg::LimitWidth-1:0]      limit_i,
  input  lhm_pkg::item_t                      item_i,
  output lhm_pkg::result_t                    result_o
);
  import lhm_pkg::*;

  link_state_e            state_q, state_d, seen;
  logic [LimitWidth-1:0]  run_q, run_d;
  logic [COUNT_WIDTH-1:0] checks_q, checks_d;
  logic [COUNT_WIDTH-1:0] fails_q, fails_d;
  logic [HoldWidth-1:0]   rtt_q, rtt_d;
  logic                   echo_q, echo_d;
  logic                   lookup_q, lookup_d;
  logic [TimeWidth-1:0]   check_stamp_q, check_stamp_d;
  logic [TimeWidth-1:0]   change_stamp_q, change_stamp_d;
  logic                   changed;
  notice_e                notice;
  logic [63:0]            checks_wide, fails_wide;

  always_comb begin
    priority if (item_i.echo_ok && item_i.lookup_ok) begin
      seen = ST_UP;
    end else if (!item_i.echo_ok && !item_i.lookup_ok) begin
      seen = ST_DOWN;
    end else begin
      seen = ST_DEGRADED;
    end
  end

  always_comb begin
    state_d       = state_q;
    run_d         = run_q;
    checks_d      = checks_q;
    fails_d       = fails_q;
    rtt_d         = rtt_q;
    echo_d        = echo_q;
    lookup_d      = lookup_q;
    check_stamp_d = check_stamp_q;
    notice        = NOTICE_NONE;
    if (item_i.op == OpForceUnknown) begin
      state_d = ST_UNKNOWN;
      run_d   = '0;
    end else begin
      if (seen == ST_UP) begin
        run_d   = '0;
        state_d = ST_UP;
      end else begin
        run_d   = (run_q == RunMax) ? RunMax : run_q + 1'b1;
        fails_d = fails_q + 1'b1;
        if (run_d >= limit_i || state_q != ST_UP) begin
          state_d = seen;
        end
      end
      checks_d      = checks_q + 1'b1;
      echo_d        = item_i.echo_ok;
      lookup_d      = item_i.lookup_ok;
      check_stamp_d = item_i.now_seconds;
      if (item_i.echo_ok) begin
        rtt_d = {1'b0, item_i.round_trip_ms};
      end
      if (state_d != state_q) begin
        priority if (state_d == ST_UP) begin
          notice = (state_q != ST_UNKNOWN) ? NOTICE_BACK_UP : NOTICE_NONE;
        end else if (state_d == ST_DOWN) begin
          notice = NOTICE_DOWN;
        end else begin
          notice = item_i.echo_ok ? NOTICE_LOOKUP_BAD : NOTICE_ECHO_BAD;
        end
      end
    end
  end

  assign changed        = (state_d != state_q);
  assign change_stamp_d = changed ? item_i.now_seconds : change_stamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_UNKNOWN;
      run_q          <= '0;
      checks_q       <= '0;
      fails_q        <= '0;
      rtt_q          <= RttNone;
      echo_q         <= 1'b0;
      lookup_q       <= 1'b0;
      check_stamp_q  <= '0;
      change_stamp_q <= '0;
    end else if (fire_i) begin
      state_q        <= state_d;
      run_q          <= run_d;
      checks_q       <= checks_d;
      fails_q        <= fails_d;
      rtt_q          <= rtt_d;
      echo_q         <= echo_d;
      lookup_q       <= lookup_d;
      check_stamp_q  <= check_stamp_d;
      change_stamp_q <= change_stamp_d;
    end
  end

  assign checks_wide = 64'(checks_d);
  assign fails_wide  = 64'(fails_d);

  always_comb begin
    result_o.link_state      = state_code(state_d);
    result_o.prior_state     = state_code(state_q);
    result_o.state_changed   = changed;
    result_o.notice          = notice;
    result_o.check_total     = checks_wide[TotalWidth-1:0];
    result_o.failure_total   = fails_wide[TotalWidth-1:0];
    result_o.last_round_trip = rtt_d;
    result_o.last_echo_ok    = echo_d;
    result_o.last_lookup_ok  = lookup_d;
    result_o.last_check_time = check_stamp_d;
    result_o.changed_time    = change_stamp_d;
  end

endmodule

`default_nettype wire

// ===== sv/link_health_hysteresis_monitor.sv =====
// ----------------------------------------------------------------------------
// link_health_hysteresis_monitor
// link health tracker with failure streak hysteresis over probe requests
// pipeline: a request is held in the input register, then its result in the result register
// throughput: one request per cycle while out_o.ready is high, set by the input and result registers
// reset: link unknown, counters and stamps zero, round trip -1, limit 3
// ----------------------------------------------------------------------------
`default_nettype none

module link_health_hysteresis_monitor #(
  parameter int unsigned COUNT_WIDTH = lhm_pkg::CountWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lhm_cfg_if.sink    cfg_i,
  lhm_in_if.sink     in_i,
  lhm_out_if.source  out_o
);
  import lhm_pkg::*;

  logic [LimitWidth-1:0] limit_q;
  logic                  in_valid_q;
  item_t                 item_q;
  logic                  res_valid_q;
  result_t               res_q;
  result_t               res_d;
  logic                  advance;
  logic                  fire;
  logic                  in_take;

  assign advance  = !res_valid_q || out_o.ready;
  assign fire     = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DefFailLimit;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.fail_streak_limit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        res_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.op            <= in_i.op;
      item_q.echo_ok       <= in_i.echo_ok;
      item_q.lookup_ok     <= in_i.lookup_ok;
      item_q.round_trip_ms <= in_i.round_trip_ms;
      item_q.now_seconds   <= in_i.now_seconds;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  lhm_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .limit_i  (limit_q),
    .item_i   (item_q),
    .result_o (res_d)
  );

  assign out_o.valid           = res_valid_q;
  assign out_o.link_state      = res_q.link_state;
  assign out_o.prior_state     = res_q.prior_state;
  assign out_o.state_changed   = res_q.state_changed;
  assign out_o.notice          = res_q.notice;
  assign out_o.check_total     = res_q.check_total;
  assign out_o.failure_total   = res_q.failure_total;
  assign out_o.last_round_trip = res_q.last_round_trip;
  assign out_o.last_echo_ok    = res_q.last_echo_ok;
  assign out_o.last_lookup_ok  = res_q.last_lookup_ok;
  assign out_o.last_check_time = res_q.last_check_time;
  assign out_o.changed_time    = res_q.changed_time;

endmodule

`default_nettype wire
